@@ design/sspd_pkg.sv @@
// Shared types and constants for the slope-sign peak detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package sspd_pkg;

    // Fixed field widths of the stream and register interface
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 8;
    localparam int WIDTH_W  = 10;
    localparam int HALF_W   = 5;
    localparam int PEAKV_W  = 16;
    localparam int SIDE_W   = 9;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 16;

    // Bin counter: counts to 2*MAX_BINS-1 then folds back to MAX_BINS
    localparam int MAX_BINS = 256;
    localparam int CNT_W    = $clog2(2 * MAX_BINS);

    // Signed work width for run widths and the width threshold compare
    localparam int CMP_W    = WIDTH_W + 1;

    // Register indexes
    localparam logic [CFG_AW-1:0] CFG_HALF_WINDOW    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_MIN_PEAK_VALUE = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_MIN_SIDE_WIDTH = 2'd2;

    typedef enum logic [1:0] {
        SLOPE_FLAT = 2'd0,
        SLOPE_FALL = 2'd1,
        SLOPE_RISE = 2'd2
    } slope_t;

    // One bin after the window stage: the new bin and its window taps
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;  // newest bin
        logic [SAMPLE_W-1:0] oldest;  // bin 2h back
        logic [SAMPLE_W-1:0] mid;     // bin h back (centre)
        logic [SAMPLE_W-1:0] side;    // bin h+1 back
        logic [POS_W-1:0]    center;  // centre position
        logic                first;   // first bin of the frame
        logic                judge;   // window full, slope valid
        logic                hzero;   // zero half window
        logic                last;
    } stage_t;

    typedef struct packed {
        logic                      accepted;
        logic [SAMPLE_W-1:0]       peak_value;
        logic signed [WIDTH_W-1:0] fall_width;
        logic signed [WIDTH_W-1:0] rise_width;
        logic [POS_W-1:0]          peak_pos;
    } result_t;

endpackage

`default_nettype wire

@@ design/slope_sign_peak_detector.sv @@
// Slope-sign peak detector: each bin passes the window buffer stage, then the
// tracker and result register stage, whose output is m_tdata; throughput one
// bin per cycle unless a held result stalls the tracker. A held result only
// stalls the input when the next bin also produces a peak.
// rst_n (async, active low) clears frame state, handshakes and restores
// registers to half_window=1, min_peak_value=0, min_side_width=2.
`default_nettype none

module slope_sign_peak_detector
    import sspd_pkg::*;
#(
    parameter int MAX_HALF = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Configuration write port
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_AW-1:0] cfg_addr,
    input  wire logic [CFG_DW-1:0] cfg_wdata,
    // Input bins
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,   // [15:0] sample
    input  wire logic              s_tlast,   // last bin of the frame
    // Peak results
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [47:0]            m_tdata    // [7:0] peak_pos, [17:8] rise_width,
                                              // [27:18] fall_width, [43:28] peak_value,
                                              // [44] accepted, [47:45] zero
);

    logic [HALF_W-1:0]  half_window_reg;
    logic [PEAKV_W-1:0] min_peak_value_reg;
    logic [SIDE_W-1:0]  min_side_width_reg;

    logic    stage_valid, take;
    stage_t  stage;
    result_t res;

    // Register file; the user must issue writes only while the block is idle (not enforced here)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_window_reg    <= HALF_W'(1);
            min_peak_value_reg <= '0;
            min_side_width_reg <= SIDE_W'(2);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_HALF_WINDOW:    half_window_reg    <= cfg_wdata[HALF_W-1:0];
                CFG_MIN_PEAK_VALUE: min_peak_value_reg <= cfg_wdata[PEAKV_W-1:0];
                CFG_MIN_SIDE_WIDTH: min_side_width_reg <= cfg_wdata[SIDE_W-1:0];
                default:            ;
            endcase
        end
    end

    // Stage 1: write the bin into the circular window and fetch the taps
    // at 2h, h and h+1 bins back (h clamped to MAX_HALF).
    sspd_window #(
        .MAX_HALF (MAX_HALF)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .half_window (half_window_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .sample      (s_tdata[SAMPLE_W-1:0]),
        .last        (s_tlast),
        .take        (take),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    // Stage 2: slope classification, rise/fall run tracking and the
    // result register. A fall ending in a rise or flat emits one request.
    sspd_track u_track (
        .clk            (clk),
        .rst_n          (rst_n),
        .min_peak_value (min_peak_value_reg),
        .min_side_width (min_side_width_reg),
        .stage_valid    (stage_valid),
        .stage          (stage),
        .take           (take),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_data       (res)
    );

    assign m_tdata = {3'b000, res.accepted, res.peak_value, res.fall_width,
                      res.rise_width, res.peak_pos};

endmodule

`default_nettype wire

@@ design/sspd_window.sv @@
// Window stage: circular sample buffer, bin counter and tap reads.
// Depends on sspd_pkg.
`default_nettype none

module sspd_window
    import sspd_pkg::*;
#(
    parameter int MAX_HALF = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [HALF_W-1:0]   half_window,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [SAMPLE_W-1:0] sample,
    input  wire logic                last,
    input  wire logic                take,
    output logic                     stage_valid,
    output stage_t                   stage
);

    localparam int HW    = $clog2(MAX_HALF + 1);
    localparam int AW    = $clog2(2 * MAX_HALF + 1);
    localparam int DEPTH = 2 ** AW;

    logic [SAMPLE_W-1:0] win_a_mem [DEPTH];
    logic [SAMPLE_W-1:0] win_b_mem [DEPTH];

    logic [AW-1:0]    wptr_reg, wptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg, valid_next;
    stage_t           stage_reg;

    logic [HW-1:0] h_eff;
    logic [AW-1:0] rd_old, rd_mid, rd_side;
    logic          accept;

    assign h_eff = (32'(half_window) > MAX_HALF) ? HW'(MAX_HALF) : HW'(half_window);

    assign rd_old  = wptr_reg - AW'({h_eff, 1'b0});
    assign rd_mid  = wptr_reg - AW'(h_eff);
    assign rd_side = wptr_reg - AW'(h_eff) - AW'(1);

    assign in_ready = !valid_reg || take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        wptr_next  = wptr_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next = 1'b1;
            wptr_next  = wptr_reg + AW'(1);
            if (last)
            begin
                cnt_next = '0;
            end
            else if (32'(cnt_reg) + 1 >= 2 * MAX_BINS)
            begin
                cnt_next = CNT_W'(MAX_BINS);
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    // Buffer write and tap reads share the accept edge; reads see older bins only
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_a_mem[wptr_reg] <= sample;
            win_b_mem[wptr_reg] <= sample;
            stage_reg.oldest    <= win_a_mem[rd_old];
            stage_reg.mid       <= win_a_mem[rd_mid];
            stage_reg.side      <= win_b_mem[rd_side];
            stage_reg.sample    <= sample;
            stage_reg.center    <= POS_W'(cnt_reg - CNT_W'(h_eff));
            stage_reg.first     <= (cnt_reg == '0);
            stage_reg.judge     <= (32'(cnt_reg) >= 2 * 32'(h_eff));
            stage_reg.hzero     <= (h_eff == '0);
            stage_reg.last      <= last;
        end
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

endmodule

`default_nettype wire

@@ design/sspd_track.sv @@
// Slope tracking: classifies the centre slope, follows rise and fall runs
// and holds the result register. Depends on sspd_pkg.
`default_nettype none

module sspd_track
    import sspd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [PEAKV_W-1:0] min_peak_value,
    input  wire logic [SIDE_W-1:0]  min_side_width,
    input  wire logic               stage_valid,
    input  wire stage_t             stage,
    output logic                    take,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output result_t                 out_data
);

    slope_t              prev_slope_reg, prev_slope_next;
    logic [POS_W-1:0]    rise_start_reg, rise_start_next;
    logic [POS_W-1:0]    rise_end_reg, rise_end_next;
    logic [POS_W-1:0]    fall_start_reg, fall_start_next;
    logic [SAMPLE_W-1:0] rise_end_value_reg, rise_end_value_next;
    logic [SAMPLE_W-1:0] fall_start_value_reg, fall_start_value_next;
    logic                out_valid_reg;
    result_t             out_reg;

    slope_t                  cur;
    logic                    start_rise, turn, emit, out_free;
    logic signed [CMP_W-1:0] rw, fw, min_w;
    logic [POS_W-1:0]        pos;
    logic [SAMPLE_W-1:0]     val;
    logic                    ok;

    always_comb
    begin
        if (stage.hzero || stage.sample == stage.oldest)
        begin
            cur = SLOPE_FLAT;
        end
        else if (stage.sample > stage.oldest)
        begin
            cur = SLOPE_RISE;
        end
        else
        begin
            cur = SLOPE_FALL;
        end
    end

    assign start_rise = stage.judge && prev_slope_reg == SLOPE_FLAT && cur == SLOPE_RISE;
    assign turn       = stage.judge && prev_slope_reg == SLOPE_RISE && cur == SLOPE_FALL;
    assign emit       = stage.judge && prev_slope_reg == SLOPE_FALL
                        && (cur == SLOPE_RISE || cur == SLOPE_FLAT);

    assign out_free = !out_valid_reg || out_ready;
    assign take     = stage_valid && (!emit || out_free);

    // Fall end is centre-1, so the fall width is centre - fall_start
    assign rw    = CMP_W'(rise_end_reg) - CMP_W'(rise_start_reg) + CMP_W'(1);
    assign fw    = CMP_W'(stage.center) - CMP_W'(fall_start_reg);
    assign min_w = CMP_W'(min_side_width);

    always_comb
    begin
        if (rise_end_value_reg < fall_start_value_reg)
        begin
            pos = fall_start_reg;
            val = fall_start_value_reg;
        end
        else
        begin
            pos = rise_end_reg;
            val = rise_end_value_reg;
        end
    end

    assign ok = (val > min_peak_value) && (rw >= min_w) && (fw >= min_w);

    always_comb
    begin
        prev_slope_next       = prev_slope_reg;
        rise_start_next       = rise_start_reg;
        rise_end_next         = rise_end_reg;
        fall_start_next       = fall_start_reg;
        rise_end_value_next   = rise_end_value_reg;
        fall_start_value_next = fall_start_value_reg;
        if (stage.first)
        begin
            rise_end_value_next   = stage.sample;
            fall_start_value_next = stage.sample;
        end
        if (start_rise)
        begin
            rise_start_next = stage.center;
        end
        else if (turn)
        begin
            rise_end_next         = stage.center - POS_W'(1);
            fall_start_next       = stage.center;
            rise_end_value_next   = stage.side;
            fall_start_value_next = stage.mid;
        end
        if (stage.judge)
        begin
            prev_slope_next = cur;
        end
        if (stage.last)
        begin
            prev_slope_next       = SLOPE_FLAT;
            rise_start_next       = '0;
            rise_end_next         = '0;
            fall_start_next       = '0;
            rise_end_value_next   = '0;
            fall_start_value_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_slope_reg       <= SLOPE_FLAT;
            rise_start_reg       <= '0;
            rise_end_reg         <= '0;
            fall_start_reg       <= '0;
            rise_end_value_reg   <= '0;
            fall_start_value_reg <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                prev_slope_reg       <= prev_slope_next;
                rise_start_reg       <= rise_start_next;
                rise_end_reg         <= rise_end_next;
                fall_start_reg       <= fall_start_next;
                rise_end_value_reg   <= rise_end_value_next;
                fall_start_value_reg <= fall_start_value_next;
            end
            if (take && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_reg.peak_pos   <= pos;
            out_reg.rise_width <= WIDTH_W'(rw);
            out_reg.fall_width <= WIDTH_W'(fw);
            out_reg.peak_value <= val;
            out_reg.accepted   <= ok;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // End of frame leaves the run tracker in its reset state
    assert property (@(posedge clk) disable iff (!rst_n)
        take && stage.last |=> prev_slope_reg == SLOPE_FLAT && rise_start_reg == '0
            && rise_end_value_reg == '0 && fall_start_value_reg == '0)
        else $error("run state not cleared after last bin");

    // A waiting result is never overwritten by a new peak
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !(take && emit))
        else $error("pending result overwritten");

    // A bin that makes no peak is never held back by the output side
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid && !emit |-> take)
        else $error("non-peak bin stalled");

    // A new peak is registered at the output as its bin leaves the stage
    assert property (@(posedge clk) disable iff (!rst_n)
        take && emit |=> out_valid_reg && out_reg.peak_value == $past(val))
        else $error("peak result not registered");

endmodule

`default_nettype wire
